// ===== sv/burgers_stencil_step_core_assert.svh =====
// ----------------------------------------------------------------------------
// Stencil step core assertion macros
// Concurrent assertion shorthands that use the enclosing module's clk and
// rst_n. They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BURGERS_STENCIL_STEP_CORE_ASSERT_SVH
`define BURGERS_STENCIL_STEP_CORE_ASSERT_SVH

`ifndef SYNTH

// The consequent holds in the same cycle as the antecedent.
`define BSS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent holds in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define BSS_ASSERT_IMPLY(lbl, ante, cons)
`define BSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/burg_pkg.sv =====
// ----------------------------------------------------------------------------
// Burgers stencil package
// Widths, constants, command and status types shared by the stencil core.
// ----------------------------------------------------------------------------
`default_nettype none

package burg_pkg;

  // Field widths.
  localparam int VAL_W  = 16;   // Q3.12 velocity
  localparam int GAIN_W = 18;   // Q1.16 coefficient
  localparam int GEOM_W = 11;   // grid size registers
  localparam int POS_W  = 10;   // result row and column
  localparam int DATA_W = 32;   // register bus data
  localparam int ADDR_W = 5;    // register bus byte address

  // Datapath widths.
  localparam int K_W   = 23;         // advection coefficient (gain + b*u)
  localparam int B_W   = 18;         // second multiplier operand
  localparam int P_W   = K_W + B_W;  // product
  localparam int ACC_W = 28;         // result accumulator

  // Rounding shifts: gain*u to Q.16, everything else to Q.12.
  localparam int SH_K = 12;
  localparam int SH_V = 16;

  localparam int MIN_DIM    = 3;
  localparam int FIRST_UPD  = 2;
  localparam int GRID_RESET = 1024;
  localparam int VAL_MAX    = 32767;
  localparam int VAL_MIN    = -32768;

  typedef enum logic [2:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_DIFF_X_GAIN = 3'd2,
    REG_DIFF_Y_GAIN = 3'd3,
    REG_ADV_X_GAIN  = 3'd4,
    REG_ADV_Y_GAIN  = 3'd5,
    REG_BURG_X_GAIN = 3'd6,
    REG_BURG_Y_GAIN = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MS_BX,
    MS_BY,
    MS_DX,
    MS_DY,
    MS_AX,
    MS_AY
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic [GEOM_W-1:0]        grid_cols;
    logic [GEOM_W-1:0]        grid_rows;
    logic signed [GAIN_W-1:0] diff_x_gain;
    logic signed [GAIN_W-1:0] diff_y_gain;
    logic signed [GAIN_W-1:0] adv_x_gain;
    logic signed [GAIN_W-1:0] adv_y_gain;
    logic signed [GAIN_W-1:0] burg_x_gain;
    logic signed [GAIN_W-1:0] burg_y_gain;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     kx_load;
    logic     ky_load;
    acc_op_t  acc_op;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/burg_if.sv =====
// ----------------------------------------------------------------------------
// Burgers stencil stream interfaces
// Valid/ready channels for incoming grid cells and outgoing updated cells.
// ----------------------------------------------------------------------------
`default_nettype none

interface burg_in_if
  import burg_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface burg_out_if
  import burg_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] new_value;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    frame_last;

  modport source (output valid, output new_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input new_value, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/burg_cfg.sv =====
// ----------------------------------------------------------------------------
// Burgers stencil configuration registers
// APB-style register file holding grid geometry and the update gains.
// ----------------------------------------------------------------------------
`default_nettype none

module burg_cfg
  import burg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_cols   <= GEOM_W'(GRID_RESET);
      cfg_r.grid_rows   <= GEOM_W'(GRID_RESET);
      cfg_r.diff_x_gain <= '0;
      cfg_r.diff_y_gain <= '0;
      cfg_r.adv_x_gain  <= '0;
      cfg_r.adv_y_gain  <= '0;
      cfg_r.burg_x_gain <= '0;
      cfg_r.burg_y_gain <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_GRID_COLS:   cfg_r.grid_cols   <= pwdata[GEOM_W-1:0];
        REG_GRID_ROWS:   cfg_r.grid_rows   <= pwdata[GEOM_W-1:0];
        REG_DIFF_X_GAIN: cfg_r.diff_x_gain <= pwdata[GAIN_W-1:0];
        REG_DIFF_Y_GAIN: cfg_r.diff_y_gain <= pwdata[GAIN_W-1:0];
        REG_ADV_X_GAIN:  cfg_r.adv_x_gain  <= pwdata[GAIN_W-1:0];
        REG_ADV_Y_GAIN:  cfg_r.adv_y_gain  <= pwdata[GAIN_W-1:0];
        REG_BURG_X_GAIN: cfg_r.burg_x_gain <= pwdata[GAIN_W-1:0];
        REG_BURG_Y_GAIN: cfg_r.burg_y_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_GRID_COLS:   prdata[GEOM_W-1:0] = cfg_r.grid_cols;
      REG_GRID_ROWS:   prdata[GEOM_W-1:0] = cfg_r.grid_rows;
      REG_DIFF_X_GAIN: prdata[GAIN_W-1:0] = cfg_r.diff_x_gain;
      REG_DIFF_Y_GAIN: prdata[GAIN_W-1:0] = cfg_r.diff_y_gain;
      REG_ADV_X_GAIN:  prdata[GAIN_W-1:0] = cfg_r.adv_x_gain;
      REG_ADV_Y_GAIN:  prdata[GAIN_W-1:0] = cfg_r.adv_y_gain;
      REG_BURG_X_GAIN: prdata[GAIN_W-1:0] = cfg_r.burg_x_gain;
      REG_BURG_Y_GAIN: prdata[GAIN_W-1:0] = cfg_r.burg_y_gain;
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/burg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Burgers stencil controller
// Sequences one item: line store access, six products on the shared
// multiplier, and the hand-off into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module burg_ctrl
  import burg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_LOAD = 9'b0_0000_0010,
    S_MBX  = 9'b0_0000_0100,
    S_MBY  = 9'b0_0000_1000,
    S_MDX  = 9'b0_0001_0000,
    S_MDY  = 9'b0_0010_0000,
    S_MAX  = 9'b0_0100_0000,
    S_MAY  = 9'b0_1000_0000,
    S_FIN  = 9'b1_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MS_BX;
    cmd.acc_op  = ACC_HOLD;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sts.has_result ? S_MBX : S_IDLE;
      end
      S_MBX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_BX;
        cmd.acc_op  = ACC_INIT;
        state_nxt   = S_MBY;
      end
      S_MBY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_BY;
        cmd.kx_load = 1'b1;
        state_nxt   = S_MDX;
      end
      S_MDX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DX;
        cmd.ky_load = 1'b1;
        state_nxt   = S_MDY;
      end
      S_MDY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DY;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_MAX;
      end
      S_MAX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AX;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_MAY;
      end
      S_MAY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AY;
        cmd.acc_op  = ACC_SUB;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // Wait here while the output register still holds an untaken item.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `include "burgers_stencil_step_core_assert.svh"

  `BSS_ASSERT_NEXT(a_accept_then_load, cmd.accept, state_r == S_LOAD)
  `BSS_ASSERT_NEXT(a_halo_returns_idle, (state_r == S_LOAD) && !sts.has_result, state_r == S_IDLE)

endmodule

`default_nettype wire

// ===== sv/burg_dp.sv =====
// ----------------------------------------------------------------------------
// Burgers stencil datapath
// Raster counters, two line stores, the four-cell window, a shared
// multiplier with rounding, the accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module burg_dp
  import burg_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic signed [VAL_W-1:0] in_cell_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_new_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    out_frame_last
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic signed [P_W-1:0] HALF_K = P_W'(1) << (SH_K - 1);
  localparam logic signed [P_W-1:0] HALF_V = P_W'(1) << (SH_V - 1);

  // Effective geometry, clamped to what the stores and counters support.
  logic [CW:0] cols;
  logic [RW:0] rows;

  always_comb begin
    if (cfg.grid_cols < GEOM_W'(MIN_DIM)) begin
      cols = (CW+1)'(MIN_DIM);
    end else if (32'(cfg.grid_cols) > 32'(MAX_COLS)) begin
      cols = (CW+1)'(MAX_COLS);
    end else begin
      cols = (CW+1)'(cfg.grid_cols);
    end
    if (cfg.grid_rows < GEOM_W'(MIN_DIM)) begin
      rows = (RW+1)'(MIN_DIM);
    end else if (32'(cfg.grid_rows) > 32'(MAX_ROWS)) begin
      rows = (RW+1)'(MAX_ROWS);
    end else begin
      rows = (RW+1)'(cfg.grid_rows);
    end
  end

  // Raster position of the next incoming cell.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW:0]   col_p1;
  logic [RW:0]   row_p1;
  logic          has_res, is_last;

  assign col_p1 = {1'b0, col_r} + (CW+1)'(1);
  assign row_p1 = {1'b0, row_r} + (RW+1)'(1);

  always_comb begin
    col_nxt = col_p1[CW-1:0];
    row_nxt = row_r;
    if (col_p1 >= cols) begin
      col_nxt = '0;
      row_nxt = (row_p1 >= rows) ? '0 : row_p1[RW-1:0];
    end
  end

  assign has_res = (row_r >= RW'(FIRST_UPD)) && (col_r >= CW'(FIRST_UPD)) &&
                   ({1'b0, row_r} < rows) && ({1'b0, col_r} < cols);
  assign is_last = ({1'b0, row_r} == rows - (RW+1)'(1)) &&
                   ({1'b0, col_r} == cols - (CW+1)'(1));

  logic                    has_res_r;
  logic [CW-1:0]           addr_r;
  logic signed [VAL_W-1:0] x_r;
  logic [POS_W-1:0]        pos_row_r, pos_col_r;
  logic                    last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      has_res_r <= 1'b0;
    end else if (cmd.accept) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      has_res_r <= has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r    <= col_r;
      x_r       <= in_cell_value;
      pos_row_r <= POS_W'(row_r - RW'(1));
      pos_col_r <= POS_W'(col_r - CW'(1));
      last_r    <= is_last;
    end
  end

  // Line stores: read at acceptance, written back in the following cycle.
  logic signed [VAL_W-1:0] upper_mem  [MAX_COLS];
  logic signed [VAL_W-1:0] middle_mem [MAX_COLS];
  logic signed [VAL_W-1:0] rd_mid_r, rd_up_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_mid_r <= middle_mem[col_r];
      rd_up_r  <= upper_mem[col_r];
    end
    if (cmd.load) begin
      upper_mem[addr_r]  <= rd_mid_r;
      middle_mem[addr_r] <= x_r;
    end
  end

  // Window: west and center of the row above, north and south of center.
  logic signed [VAL_W-1:0] win_w_r, win_c_r, win_n_r, win_s_r;
  logic signed [VAL_W-1:0] u_r;
  logic signed [B_W-1:0]   d2x_r, d2y_r;
  logic signed [VAL_W:0]   dux_r, duy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= '0;
      win_c_r <= '0;
      win_n_r <= '0;
      win_s_r <= '0;
    end else if (cmd.load) begin
      win_w_r <= win_c_r;
      win_c_r <= rd_mid_r;
      win_n_r <= rd_up_r;
      win_s_r <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r   <= win_c_r;
      d2x_r <= B_W'(rd_mid_r) + B_W'(win_w_r) - (B_W'(win_c_r) <<< 1);
      d2y_r <= B_W'(win_s_r) + B_W'(win_n_r) - (B_W'(win_c_r) <<< 1);
      dux_r <= (VAL_W+1)'(win_c_r) - (VAL_W+1)'(win_w_r);
      duy_r <= (VAL_W+1)'(win_c_r) - (VAL_W+1)'(win_n_r);
    end
  end

  // Shared multiplier, product registered before any use.
  logic signed [K_W-1:0]   op_a;
  logic signed [B_W-1:0]   op_b;
  logic signed [P_W-1:0]   prod, p_r;
  logic signed [K_W-1:0]   kx_r, ky_r;

  always_comb begin
    case (cmd.mul_sel)
      MS_BX: begin
        op_a = K_W'(cfg.burg_x_gain);
        op_b = B_W'(u_r);
      end
      MS_BY: begin
        op_a = K_W'(cfg.burg_y_gain);
        op_b = B_W'(u_r);
      end
      MS_DX: begin
        op_a = K_W'(cfg.diff_x_gain);
        op_b = d2x_r;
      end
      MS_DY: begin
        op_a = K_W'(cfg.diff_y_gain);
        op_b = d2y_r;
      end
      MS_AX: begin
        op_a = kx_r;
        op_b = B_W'(dux_r);
      end
      MS_AY: begin
        op_a = ky_r;
        op_b = B_W'(duy_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = P_W'(op_a) * P_W'(op_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r <= prod;
    end
  end

  // Round half up: add half an LSB, then shift arithmetically.
  logic signed [P_W-1:0]   rk_full, rv_full;
  logic signed [K_W-1:0]   rk;
  logic signed [ACC_W-1:0] rv;

  assign rk_full = (p_r + HALF_K) >>> SH_K;
  assign rv_full = (p_r + HALF_V) >>> SH_V;
  assign rk      = rk_full[K_W-1:0];
  assign rv      = rv_full[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.kx_load) begin
      kx_r <= K_W'(cfg.adv_x_gain) + rk;
    end
    if (cmd.ky_load) begin
      ky_r <= K_W'(cfg.adv_y_gain) + rk;
    end
  end

  logic signed [ACC_W-1:0] acc_r, fin;
  logic signed [VAL_W-1:0] sat;

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_INIT: acc_r <= ACC_W'(u_r);
      ACC_ADD:  acc_r <= acc_r + rv;
      ACC_SUB:  acc_r <= acc_r - rv;
      default:  acc_r <= acc_r;
    endcase
  end

  // The last product is subtracted on the way into the output register.
  assign fin = acc_r - rv;

  always_comb begin
    if (fin > ACC_W'(VAL_MAX)) begin
      sat = VAL_W'(VAL_MAX);
    end else if (fin < ACC_W'(VAL_MIN)) begin
      sat = VAL_W'(VAL_MIN);
    end else begin
      sat = fin[VAL_W-1:0];
    end
  end

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [POS_W-1:0]        out_row_r, out_col_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val_r  <= sat;
      out_row_r  <= pos_row_r;
      out_col_r  <= pos_col_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_value  = out_val_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

  assign sts.has_result = has_res_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  `include "burgers_stencil_step_core_assert.svh"

  `BSS_ASSERT_IMPLY(a_out_no_overwrite, cmd.out_load, !out_valid_r || out_ready)
  `BSS_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid_r)

endmodule

`default_nettype wire

// ===== sv/burgers_stencil_step_core.sv =====
// ----------------------------------------------------------------------------
// Burgers stencil step core
// One explicit upwind time step of the 2-D viscous Burgers equation.
// ----------------------------------------------------------------------------
// Grid cells, halo included, enter in raster order on in_chan (valid/ready).
// For each cell that completes the neighborhood of an interior cell, one
// updated value with its row and column leaves on out_chan; halo positions
// produce nothing. frame_last marks the last interior cell of the frame.
// Geometry and gains sit in eight registers on the APB-style port; write them
// only while the core is idle. The core itself does not enforce this.
// An item that yields a result goes from acceptance through the load, six
// multiply and final states to the output register; the next item is taken
// only in idle. The six products of the update share one multiplier, one
// product per cycle. A halo cell only reads and writes back the line store.
// The output register lets a new item be accepted while a result waits; a
// stalled receiver holds the core only when the next result is ready.
// Reset clears counters, window and registers; the line stores need no
// clearing, since within a frame no unwritten entry reaches a result.
// ----------------------------------------------------------------------------
`default_nettype none

module burgers_stencil_step_core
  import burg_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  burg_in_if.sink           in_chan,
  burg_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  burg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  burg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  burg_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_cell_value  (in_chan.cell_value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_new_value  (out_chan.new_value),
    .out_row        (out_chan.out_row),
    .out_col        (out_chan.out_col),
    .out_frame_last (out_chan.frame_last)
  );

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

// ===== dv/tb_burgers_stencil_step_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Burgers stencil step core
// Streams grid frames through the core with random source gaps and sink
// stalls, rewrites geometry and gains between frames, and checks every
// updated cell against a line-store model of the upwind stencil update.
// ----------------------------------------------------------------------------

module tb_burgers_stencil_step_core
  import burg_pkg::*;
();

  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROWS     = 1024;
  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef enum bit [1:0] {
    ST_CELL,
    ST_CELL_TYPED,
    ST_REG
  } stim_op_t;

  typedef struct packed {
    stim_op_t                 op;
    reg_idx_t                 idx;
    logic signed [31:0]       value;
    logic signed [VAL_W-1:0]  typed_value;
  } stim_row_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } cell_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  burg_in_if  in_chan ();
  burg_out_if out_chan ();

  burgers_stencil_step_core #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: configuration, two line stores, the four-cell window and
  // the raster position of the next cell.
  cfg_t                    model_cfg;
  logic signed [VAL_W-1:0] upper_line [MAX_COLS] = '{default: '0};
  logic signed [VAL_W-1:0] middle_line [MAX_COLS] = '{default: '0};
  logic signed [VAL_W-1:0] win_west   = '0;
  logic signed [VAL_W-1:0] win_center = '0;
  logic signed [VAL_W-1:0] win_north  = '0;
  logic signed [VAL_W-1:0] win_south  = '0;
  int unsigned             row_pos = 0;
  int unsigned             col_pos = 0;

  cell_result_t updated_cells_q [$];
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           allow_gaps = 1'b1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [GEOM_W-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Round half up, then floor-divide by 2^sh.
  function automatic longint round_shift(input longint p, input int sh);
    return (p + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic bit advance_stencil(input logic signed [VAL_W-1:0] x,
                                         output cell_result_t res);
    int unsigned             cols, rows, c;
    logic signed [VAL_W-1:0] mid_c, up_c;
    longint                  u, uw, ue, un, us, d_xx, d_yy, k_x, k_y, adv_x, adv_y, sum;
    bit                      produced;
    cols  = clamp_dim(model_cfg.grid_cols, MAX_COLS);
    rows  = clamp_dim(model_cfg.grid_rows, MAX_ROWS);
    c     = col_pos % MAX_COLS;
    mid_c = middle_line[c];
    up_c  = upper_line[c];
    res   = '0;
    produced = row_pos >= FIRST_UPD && col_pos >= FIRST_UPD &&
               row_pos < rows && col_pos < cols;
    if (produced) begin
      u  = win_center;
      uw = win_west;
      ue = mid_c;
      un = win_north;
      us = win_south;
      d_xx = round_shift(longint'(model_cfg.diff_x_gain) * (ue - 2 * u + uw), SH_V);
      d_yy = round_shift(longint'(model_cfg.diff_y_gain) * (us - 2 * u + un), SH_V);
      k_x = longint'(model_cfg.adv_x_gain) +
            round_shift(longint'(model_cfg.burg_x_gain) * u, SH_K);
      k_y = longint'(model_cfg.adv_y_gain) +
            round_shift(longint'(model_cfg.burg_y_gain) * u, SH_K);
      adv_x = round_shift(k_x * (u - uw), SH_V);
      adv_y = round_shift(k_y * (u - un), SH_V);
      sum = u + d_xx + d_yy - adv_x - adv_y;
      if (sum > VAL_MAX) sum = VAL_MAX;
      if (sum < VAL_MIN) sum = VAL_MIN;
      res.value = sum[VAL_W-1:0];
      res.row   = POS_W'(row_pos - 1);
      res.col   = POS_W'(col_pos - 1);
      res.last  = (row_pos == rows - 1) && (col_pos == cols - 1);
    end
    upper_line[c]  = mid_c;
    middle_line[c] = x;
    win_west       = win_center;
    win_center     = mid_c;
    win_north      = up_c;
    win_south      = x;
    // A position at or past the last index wraps, also after a geometry change.
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return produced;
  endfunction

  task automatic send_cell(input logic signed [VAL_W-1:0] value, input bit typed,
                           input logic signed [VAL_W-1:0] typed_value);
    cell_result_t res;
    if (allow_gaps && $urandom_range(0, 7) == 0) begin
      in_chan.valid      <= 1'b0;
      in_chan.cell_value <= VAL_W'($urandom);
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.cell_value <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (advance_stencil(value, res)) begin
      if (typed) res.value = typed_value;
      updated_cells_q.push_back(res);
    end
    @(negedge clk);
  endtask

  // Registers change only with the core drained; halo cells give no result,
  // so a few extra cycles cover any cell still in flight.
  task automatic write_reg(input reg_idx_t idx, input int value);
    in_chan.valid <= 1'b0;
    while (updated_cells_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GRID_COLS:   model_cfg.grid_cols   = value[GEOM_W-1:0];
      REG_GRID_ROWS:   model_cfg.grid_rows   = value[GEOM_W-1:0];
      REG_DIFF_X_GAIN: model_cfg.diff_x_gain = value[GAIN_W-1:0];
      REG_DIFF_Y_GAIN: model_cfg.diff_y_gain = value[GAIN_W-1:0];
      REG_ADV_X_GAIN:  model_cfg.adv_x_gain  = value[GAIN_W-1:0];
      REG_ADV_Y_GAIN:  model_cfg.adv_y_gain  = value[GAIN_W-1:0];
      REG_BURG_X_GAIN: model_cfg.burg_x_gain = value[GAIN_W-1:0];
      REG_BURG_Y_GAIN: model_cfg.burg_y_gain = value[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && allow_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (updated_cells_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item: expected none, got value %0d row %0d col %0d last %0b",
                 $time, out_chan.new_value, out_chan.out_row, out_chan.out_col,
                 out_chan.frame_last);
      end else begin
        want = updated_cells_q.pop_front();
        if (out_chan.new_value !== want.value || out_chan.out_row !== want.row ||
            out_chan.out_col !== want.col || out_chan.frame_last !== want.last) begin
          mismatch_count++;
          $display("%0t: mismatch: expected value %0d row %0d col %0d last %0b",
                   $time, want.value, want.row, want.col, want.last);
          $display("%0t:           got value %0d row %0d col %0d last %0b",
                   $time, out_chan.new_value, out_chan.out_row, out_chan.out_col,
                   out_chan.frame_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[burgers_stencil_step_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   directed_rows [$];
    int          random_items;
    int          frame_no;
    int          frame_len;
    int          fill_mode;
    int          base;
    int          v;
    int          cols_val;
    int          rows_val;
    int          gain;

    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_chan.valid      = 1'b0;
    in_chan.cell_value = '0;
    model_cfg           = '0;
    model_cfg.grid_cols = GEOM_W'(GRID_RESET);
    model_cfg.grid_rows = GEOM_W'(GRID_RESET);

    // Row 0 of a reset-size grid, then a shrink to 3x3 (both written as 0,
    // which clamps) while the column counter already sits past the new edge.
    // With every gain at zero the single update returns the center cell.
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 1, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_GRID_COLS, 0, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_GRID_ROWS, 0, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -1, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 100, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -100, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 7, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL_TYPED, REG_GRID_COLS, 12345, -16'sd32768});
    // Every gain at its positive extreme, checkerboard of extreme cells.
    directed_rows.push_back('{ST_REG, REG_DIFF_X_GAIN, 131071, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_DIFF_Y_GAIN, 131071, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_ADV_X_GAIN, 131071, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_ADV_Y_GAIN, 131071, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_BURG_X_GAIN, 131071, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_BURG_Y_GAIN, 131071, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 0, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 0, 16'sd0});
    // Every gain at its negative extreme.
    directed_rows.push_back('{ST_REG, REG_DIFF_X_GAIN, -131072, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_DIFF_Y_GAIN, -131072, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_ADV_X_GAIN, -131072, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_ADV_Y_GAIN, -131072, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_BURG_X_GAIN, -131072, 16'sd0});
    directed_rows.push_back('{ST_REG, REG_BURG_Y_GAIN, -131072, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 0, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, -32768, 16'sd0});
    directed_rows.push_back('{ST_CELL, REG_GRID_COLS, 32767, 16'sd0});

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ST_REG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_cell(directed_rows[i].value[VAL_W-1:0], directed_rows[i].op == ST_CELL_TYPED,
                  directed_rows[i].typed_value);
      end
    end

    // Whole frames only, so no unwritten line-store entry reaches a result.
    random_items = 0;
    frame_no     = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (frame_no < 7 || $urandom_range(0, 3) == 0) begin
        cols_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
                   ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) :
                   $urandom_range(3, 12);
        rows_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
                   ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) :
                   $urandom_range(3, 10);
        write_reg(REG_GRID_COLS, cols_val);
        write_reg(REG_GRID_ROWS, rows_val);
        for (int g = REG_DIFF_X_GAIN; g <= REG_BURG_Y_GAIN; g++) begin
          case ($urandom_range(0, 9))
            0:       gain = -131072;
            1:       gain = 131071;
            2, 3:    gain = int'($urandom_range(0, 262143)) - 131072;
            default: gain = int'($urandom_range(0, 16384)) - 8192;
          endcase
          write_reg(reg_idx_t'(g), gain);
        end
      end

      allow_gaps = (random_items < RANDOM_ITEMS - TAIL_ITEMS) && $urandom_range(0, 4) != 0;
      frame_len = clamp_dim(model_cfg.grid_cols, MAX_COLS) *
                  clamp_dim(model_cfg.grid_rows, MAX_ROWS);
      fill_mode = $urandom_range(0, 3);
      base      = int'($urandom_range(0, 16384)) - 8192;
      for (int n = 0; n < frame_len; n++) begin
        case (fill_mode)
          0, 1: v = base + int'($urandom_range(0, 1023)) - 512;
          2:    v = $urandom;
          default: begin
            case ($urandom_range(0, 3))
              0:       v = -32768;
              1:       v = 32767;
              2:       v = 0;
              default: v = $urandom;
            endcase
          end
        endcase
        send_cell(v[VAL_W-1:0], 1'b0, '0);
      end
      random_items += frame_len;
      frame_no++;
    end

    in_chan.valid <= 1'b0;
    while (updated_cells_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[burgers_stencil_step_core] OK");
    end else begin
      $display("[burgers_stencil_step_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== burgers_stencil_step_core.f =====
+incdir+sv
sv/burg_pkg.sv
sv/burg_if.sv
sv/burg_cfg.sv
sv/burg_ctrl.sv
sv/burg_dp.sv
sv/burgers_stencil_step_core.sv
dv/tb_burgers_stencil_step_core.sv
